@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL that checks itself.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property holds at every rising edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed: invariant violated");

// Antecedent at an edge implies consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: implication violated");

`endif

@@ rtl/firc_pkg.sv @@
// Shared types and codes for the circular-buffer FIR filter.
// No dependencies; used by firc_ctrl, firc_datapath and the top level.
package firc_pkg;

    // Input item command codes
    localparam logic CMD_FILTER = 1'b0;
    localparam logic CMD_COEF   = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MAC,
        ST_DRAIN,
        ST_ROUND,
        ST_EMIT
    } firc_state_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic start_sample;
        logic write_coef;
        logic issue;
        logic round;
        logic emit;
    } firc_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic issue_last;
        logic pipe_empty;
        logic out_free;
    } firc_status_t;

endpackage

@@ rtl/fir_filter_circular_unit.sv @@
// Top level of the single-channel circular-buffer FIR filter.
// Depends on firc_pkg, firc_ctrl, firc_datapath and assert_macros.svh.
//
// Usage:
//   Input channel (in_valid / in_stall): command selects the item type.
//     CMD_FILTER filters sample_in; CMD_COEF stores coef_value at coef_index
//     (indices at or above MAX_TAPS are ignored) and gives no result.
//   Output channel (out_valid / out_stall): sample_out, rounded half up and
//     saturated to Q1.15, with saturated set when the sum was clipped.
//   cfg_write / cfg_data write tap_count; write it only while the block is idle.
//   Timing: a coefficient write leaves the block idle. A sample goes from
//     acceptance to out_valid through the single multiply-accumulate
//     pipeline that visits one tap per cycle (memory read, multiply, add),
//     plus drain, rounding and output load. The next item is accepted the
//     cycle after the result is loaded, while that result may still wait.
//   Reset: a clearing pass over every entry zeros both memories; in_stall is
//     high meanwhile. Configuration writes are taken throughout.
//   A stalled result holds in the output register; a finished sample waits
//   in its last step until the register frees up.
module fir_filter_circular_unit #(
    parameter int MAX_TAPS    = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [8:0]                    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [7:0]                    coef_index,
    input  logic signed [COEF_BITS-1:0]   coef_value,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          saturated
);

    `include "assert_macros.svh"

    firc_pkg::firc_cmd_t    cmd;
    firc_pkg::firc_status_t status;

    firc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .command  (command),
        .status   (status),
        .in_stall (in_stall),
        .cmd      (cmd)
    );

    firc_datapath #(
        .MAX_TAPS    (MAX_TAPS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COEF_BITS   (COEF_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_data   (cfg_data),
        .sample_in  (sample_in),
        .coef_index (coef_index),
        .coef_value (coef_value),
        .cmd        (cmd),
        .out_stall  (out_stall),
        .status     (status),
        .out_valid  (out_valid),
        .sample_out (sample_out),
        .saturated  (saturated)
    );

    // Never start an item while the memories are being cleared
    `ASSERT_ALWAYS(a_no_start_in_clear, clk, rst_n, !(cmd.clear_step && (cmd.start_sample || cmd.write_coef)))
    // Rounding only after the multiply-accumulate pipeline has drained
    `ASSERT_IMPLIES(a_round_after_drain, clk, rst_n, cmd.round, status.pipe_empty)
    // A result is loaded only into a free output register
    `ASSERT_IMPLIES(a_emit_free, clk, rst_n, cmd.emit, status.out_free)

endmodule

@@ rtl/firc_ctrl.sv @@
// Sequencer of the FIR filter: clearing pass, tap loop, drain, rounding, output load.
// Depends on firc_pkg.
module firc_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  command,
    input  firc_pkg::firc_status_t status,
    output logic                  in_stall,
    output firc_pkg::firc_cmd_t   cmd
);

    firc_pkg::firc_state_t state_reg;
    firc_pkg::firc_state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= firc_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_stall   = 1'b1;
        unique case (state_reg)
            firc_pkg::ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (status.clear_last)
                begin
                    state_next = firc_pkg::ST_IDLE;
                end
            end
            firc_pkg::ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    if (command == firc_pkg::CMD_COEF)
                    begin
                        cmd.write_coef = 1'b1;
                    end
                    else
                    begin
                        cmd.start_sample = 1'b1;
                        state_next       = firc_pkg::ST_MAC;
                    end
                end
            end
            firc_pkg::ST_MAC:
            begin
                cmd.issue = 1'b1;
                if (status.issue_last)
                begin
                    state_next = firc_pkg::ST_DRAIN;
                end
            end
            firc_pkg::ST_DRAIN:
            begin
                if (status.pipe_empty)
                begin
                    state_next = firc_pkg::ST_ROUND;
                end
            end
            firc_pkg::ST_ROUND:
            begin
                cmd.round  = 1'b1;
                state_next = firc_pkg::ST_EMIT;
            end
            firc_pkg::ST_EMIT:
            begin
                // Hold until the output register is free
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = firc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = firc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/firc_datapath.sv @@
// Datapath of the FIR filter: delay and coefficient memories, position,
// multiply-accumulate pipeline, rounding, saturation and output register.
// Depends on firc_pkg.
module firc_datapath #(
    parameter int MAX_TAPS    = 256,
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [8:0]                    cfg_data,
    input  logic signed [SAMPLE_BITS-1:0] sample_in,
    input  logic [7:0]                    coef_index,
    input  logic signed [COEF_BITS-1:0]   coef_value,
    input  firc_pkg::firc_cmd_t           cmd,
    input  logic                          out_stall,
    output firc_pkg::firc_status_t        status,
    output logic                          out_valid,
    output logic signed [SAMPLE_BITS-1:0] sample_out,
    output logic                          saturated
);

    localparam int ADW  = $clog2(MAX_TAPS);
    localparam int TW   = $clog2(MAX_TAPS + 1);
    localparam int CMPW = (TW > 9) ? TW : 9;
    localparam int PW   = SAMPLE_BITS + COEF_BITS;
    localparam int AW   = (PW + ADW + 1 > 64) ? 64 : PW + ADW + 1;
    localparam int YW   = AW - COEF_BITS + 1;

    logic signed [SAMPLE_BITS-1:0] delay_mem [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   coef_mem  [MAX_TAPS];

    logic [8:0]                    tap_count_reg;
    logic [ADW-1:0]                clr_cnt_reg;
    logic [ADW-1:0]                pos_reg;
    logic [ADW-1:0]                rd_reg;
    logic [ADW-1:0]                k_reg;
    logic [TW-1:0]                 taps_reg;
    logic                          rdv_reg;
    logic                          mulv_reg;
    logic signed [SAMPLE_BITS-1:0] delay_q_reg;
    logic signed [COEF_BITS-1:0]   coef_q_reg;
    logic signed [PW-1:0]          prod_reg;
    logic signed [AW-1:0]          acc_reg;
    logic                          out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_out_reg;
    logic                          saturated_reg;

    logic [CMPW-1:0]               tc_ext;
    logic [TW-1:0]                 taps_now;
    logic [ADW-1:0]                pos_eff;
    logic [ADW-1:0]                pos_next;
    logic                          coef_ok;
    logic [YW-1:0]                 y;
    logic [YW-SAMPLE_BITS:0]       y_hi;
    logic                          y_fits;

    // Add with clamping at the accumulator bounds
    function automatic logic signed [AW-1:0] sat_add(
        input logic signed [AW-1:0] a,
        input logic signed [AW-1:0] b
    );
        logic [AW:0] s;
        s = {a[AW-1], a} + {b[AW-1], b};
        if (s[AW] != s[AW-1])
        begin
            return s[AW] ? {1'b1, {(AW-1){1'b0}}} : {1'b0, {(AW-1){1'b1}}};
        end
        return s[AW-1:0];
    endfunction

    // Effective tap count and write position for a new sample
    always_comb
    begin
        tc_ext = CMPW'(tap_count_reg);
        if (tc_ext == '0)
        begin
            taps_now = TW'(1);
        end
        else if (tc_ext > CMPW'(MAX_TAPS))
        begin
            taps_now = TW'(MAX_TAPS);
        end
        else
        begin
            taps_now = TW'(tc_ext);
        end
        pos_eff = (TW'(pos_reg) >= taps_now) ? '0 : pos_reg;
        if (TW'(pos_eff) + TW'(1) >= taps_now)
        begin
            pos_next = '0;
        end
        else
        begin
            pos_next = pos_eff + ADW'(1);
        end
    end

    assign coef_ok = (32'(coef_index) < 32'(MAX_TAPS));

    // Tap count register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= 9'd1;
        end
        else if (cfg_write)
        begin
            tap_count_reg <= cfg_data;
        end
    end

    // Delay line memory: clear sweep or sample store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            delay_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.start_sample)
        begin
            delay_mem[pos_eff] <= sample_in;
        end
        delay_q_reg <= delay_mem[rd_reg];
    end

    // Coefficient memory: clear sweep or coefficient store, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.clear_step)
        begin
            coef_mem[clr_cnt_reg] <= '0;
        end
        else if (cmd.write_coef && coef_ok)
        begin
            coef_mem[ADW'(coef_index)] <= coef_value;
        end
        coef_q_reg <= coef_mem[k_reg];
    end

    // Control counters and pipeline valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
            pos_reg     <= '0;
            rd_reg      <= '0;
            k_reg       <= '0;
            taps_reg    <= TW'(1);
            rdv_reg     <= 1'b0;
            mulv_reg    <= 1'b0;
        end
        else
        begin
            if (cmd.clear_step)
            begin
                clr_cnt_reg <= clr_cnt_reg + ADW'(1);
            end
            rdv_reg  <= cmd.issue;
            mulv_reg <= rdv_reg;
            if (cmd.start_sample)
            begin
                taps_reg <= taps_now;
                pos_reg  <= pos_next;
                rd_reg   <= pos_eff;
                k_reg    <= '0;
            end
            else if (cmd.issue)
            begin
                // Walk back through the delay line, wrapping at the tap count
                rd_reg <= (rd_reg == '0) ? ADW'(taps_reg - TW'(1)) : rd_reg - ADW'(1);
                k_reg  <= k_reg + ADW'(1);
            end
        end
    end

    // Multiply, accumulate, round
    always_ff @(posedge clk)
    begin
        prod_reg <= PW'(delay_q_reg) * PW'(coef_q_reg);
        if (cmd.start_sample)
        begin
            acc_reg <= '0;
        end
        else if (mulv_reg)
        begin
            acc_reg <= sat_add(acc_reg, AW'(prod_reg));
        end
        else if (cmd.round)
        begin
            acc_reg <= sat_add(acc_reg, AW'(1) <<< (COEF_BITS - 2));
        end
    end

    // Drop the fraction and saturate to the sample range
    always_comb
    begin
        y      = acc_reg[AW-1:COEF_BITS-1];
        y_hi   = y[YW-1:SAMPLE_BITS-1];
        y_fits = (&y_hi) | ~(|y_hi);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            saturated_reg <= ~y_fits;
            if (y_fits)
            begin
                sample_out_reg <= y[SAMPLE_BITS-1:0];
            end
            else if (y[YW-1])
            begin
                sample_out_reg <= {1'b1, {(SAMPLE_BITS-1){1'b0}}};
            end
            else
            begin
                sample_out_reg <= {1'b0, {(SAMPLE_BITS-1){1'b1}}};
            end
        end
    end

    // Status back to the controller
    always_comb
    begin
        status.clear_last = (clr_cnt_reg == ADW'(MAX_TAPS - 1));
        status.issue_last = (TW'(k_reg) == taps_reg - TW'(1));
        status.pipe_empty = ~rdv_reg & ~mulv_reg;
        status.out_free   = ~out_valid_reg | ~out_stall;
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = sample_out_reg;
    assign saturated  = saturated_reg;

endmodule
